// ===== rtl/tcwr_pkg.sv =====
// ----------------------------------------------------------------------------
// tcwr_pkg
// Shared widths, codes and types of the congestion window round block.
// ----------------------------------------------------------------------------
`default_nettype none

package tcwr_pkg;

   localparam int unsigned WIN_W      = 7;
   localparam int unsigned SEQ_W      = 32;
   localparam int unsigned ACK_W      = 32;
   localparam int unsigned CNT_W      = 7;
   localparam int unsigned DUP_W      = 2;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic OP_SEND = 1'b0;
   localparam logic OP_ACK  = 1'b1;

   localparam logic [CSR_ADDR_W-1:0] ADDR_INIT_WINDOW    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_INIT_THRESHOLD = 3'd4;

   localparam logic [WIN_W-1:0] INIT_WINDOW_RESET    = 7'd1;
   localparam logic [WIN_W-1:0] INIT_THRESHOLD_RESET = 7'd8;
   localparam logic [ACK_W-1:0] BASE_ACK_RESET       = 32'd1;

   localparam logic [DUP_W-1:0] DUP_MAX  = 2'd3;
   localparam logic [DUP_W-1:0] DUP_LOSS = 2'd2;

   typedef struct packed {
      logic start_send;
      logic load_seg;
      logic load_ack;
   } ctl_cmd_type;

   typedef struct packed {
      logic last_seg;
   } dp_status_type;

   typedef struct packed {
      logic [SEQ_W-1:0] seq_number;
      logic             is_segment;
      logic             last_of_run;
      logic [WIN_W-1:0] window_now;
      logic [WIN_W-1:0] threshold_now;
      logic             slow_start;
      logic             triple_dup_seen;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ===== rtl/tcwr_req_if.sv =====
// ----------------------------------------------------------------------------
// tcwr_req_if
// Request channel: send or ACK beats with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcwr_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [31:0] ack_number;

   modport source (output valid, output op, output ack_number, input ready);
   modport sink   (input valid, input op, input ack_number, output ready);
endinterface

`default_nettype wire

// ===== rtl/tcwr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tcwr_rsp_if
// Result channel: segment and ACK status beats with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcwr_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] seq_number;
   logic        is_segment;
   logic        last_of_run;
   logic [6:0]  window_now;
   logic [6:0]  threshold_now;
   logic        slow_start;
   logic        triple_dup_seen;

   modport source (output valid, output seq_number, output is_segment, output last_of_run,
                   output window_now, output threshold_now, output slow_start,
                   output triple_dup_seen, input ready);
   modport sink   (input valid, input seq_number, input is_segment, input last_of_run,
                   input window_now, input threshold_now, input slow_start,
                   input triple_dup_seen, output ready);
endinterface

`default_nettype wire

// ===== rtl/tcwr_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcwr_ctrl
// Controller: request acceptance, segment run sequencing, result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module tcwr_ctrl
   import tcwr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_op,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   input  dp_status_type status,
   output ctl_cmd_type  cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_SEND
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;
   logic      req_fire;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && slot_free;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in       = state_ff;
      cmd.start_send = 1'b0;
      cmd.load_seg   = 1'b0;
      cmd.load_ack   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_op == OP_SEND) begin
                  cmd.start_send = 1'b1;
                  state_in       = ST_SEND;
               end else begin
                  cmd.load_ack = 1'b1;
               end
            end
         end
         ST_SEND: begin
            if (slot_free) begin
               cmd.load_seg = 1'b1;
               if (status.last_seg) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (cmd.load_seg || cmd.load_ack) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/tcwr_datapath.sv =====
// ----------------------------------------------------------------------------
// tcwr_datapath
// Window state, duplicate ACK tracking, segment numbering, CSRs, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcwr_datapath
   import tcwr_pkg::*;
#(
   parameter int unsigned MAX_WINDOW = 64
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  ctl_cmd_type                cmd,
   output dp_status_type              status,
   input  wire logic [ACK_W-1:0]      req_ack_number,
   input  wire logic                  csr_write,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [WIN_W-1:0]      csr_wdata,
   output logic [CSR_DATA_W-1:0]      csr_rdata,
   output rsp_payload_type            rsp_payload
);

   localparam logic [WIN_W:0]   MAX_W8 = (WIN_W+1)'(MAX_WINDOW);
   localparam logic [WIN_W-1:0] MAX_W7 = WIN_W'(MAX_WINDOW);
   localparam logic [WIN_W-1:0] THRESHOLD_RESET =
      (INIT_THRESHOLD_RESET > MAX_W7) ? MAX_W7 : INIT_THRESHOLD_RESET;

   logic [WIN_W-1:0] init_window_ff, init_window_in;
   logic [WIN_W-1:0] init_threshold_ff, init_threshold_in;
   logic [WIN_W-1:0] window_ff, window_in;
   logic [WIN_W-1:0] threshold_ff, threshold_in;
   logic [ACK_W-1:0] base_ack_ff, base_ack_in;
   logic [ACK_W-1:0] prev_ack_ff, prev_ack_in;
   logic             prev_valid_ff, prev_valid_in;
   logic [DUP_W-1:0] dup_count_ff, dup_count_in;
   logic             loss_ff, loss_in;
   logic [CNT_W-1:0] ack_index_ff, ack_index_in;
   logic [CNT_W-1:0] seg_cnt_ff, seg_cnt_in;
   rsp_payload_type  payload_ff, payload_in;

   logic             is_dup;
   logic [DUP_W-1:0] dup_upd;
   logic             loss_upd;
   logic             closing;
   logic [WIN_W:0]   grow;
   logic [WIN_W-1:0] grown;
   logic [WIN_W-1:0] clamp_wr_window;
   logic [WIN_W-1:0] clamp_wr_threshold;

   assign status.last_seg = ({1'b0, seg_cnt_ff} + 8'd1) == {1'b0, window_ff};
   assign rsp_payload     = payload_ff;

   assign is_dup   = prev_valid_ff && (req_ack_number == prev_ack_ff);
   assign dup_upd  = !is_dup ? '0 : (dup_count_ff == DUP_MAX) ? DUP_MAX : dup_count_ff + 2'd1;
   assign loss_upd = loss_ff || (is_dup && (dup_upd == DUP_LOSS));
   assign closing  = ({1'b0, ack_index_ff} + 8'd1) >= {1'b0, window_ff};
   assign grow     = (window_ff < threshold_ff) ? {window_ff, 1'b0}
                                                : {1'b0, window_ff} + 8'd1;
   assign grown    = (grow > MAX_W8) ? MAX_W7 : grow[WIN_W-1:0];

   assign clamp_wr_window    = (csr_wdata == '0) ? 7'd1 :
                               ({1'b0, csr_wdata} > MAX_W8) ? MAX_W7 : csr_wdata;
   assign clamp_wr_threshold = ({1'b0, csr_wdata} > MAX_W8) ? MAX_W7 : csr_wdata;

   always_comb begin
      unique case (csr_addr)
         ADDR_INIT_WINDOW:    csr_rdata = {{(CSR_DATA_W-WIN_W){1'b0}}, init_window_ff};
         ADDR_INIT_THRESHOLD: csr_rdata = {{(CSR_DATA_W-WIN_W){1'b0}}, init_threshold_ff};
         default:             csr_rdata = '0;
      endcase
   end

   always_comb begin
      init_window_in    = init_window_ff;
      init_threshold_in = init_threshold_ff;
      window_in         = window_ff;
      threshold_in      = threshold_ff;
      base_ack_in       = base_ack_ff;
      prev_ack_in       = prev_ack_ff;
      prev_valid_in     = prev_valid_ff;
      dup_count_in      = dup_count_ff;
      loss_in           = loss_ff;
      ack_index_in      = ack_index_ff;
      seg_cnt_in        = seg_cnt_ff;
      payload_in        = payload_ff;

      if (cmd.start_send) begin
         ack_index_in  = '0;
         prev_valid_in = 1'b0;
         prev_ack_in   = '0;
         dup_count_in  = '0;
         loss_in       = 1'b0;
         seg_cnt_in    = '0;
      end

      if (cmd.load_seg) begin
         payload_in.seq_number      = base_ack_ff + {{(ACK_W-CNT_W){1'b0}}, seg_cnt_ff};
         payload_in.is_segment      = 1'b1;
         payload_in.last_of_run     = status.last_seg;
         payload_in.triple_dup_seen = 1'b0;
         seg_cnt_in                 = seg_cnt_ff + 7'd1;
      end

      if (cmd.load_ack) begin
         payload_in.seq_number      = '0;
         payload_in.is_segment      = 1'b0;
         payload_in.last_of_run     = 1'b1;
         payload_in.triple_dup_seen = loss_upd;
         if (closing) begin
            base_ack_in = req_ack_number;
            if (loss_upd) begin
               threshold_in = window_ff >> 1;
               window_in    = 7'd1;
            end else begin
               window_in = grown;
            end
            ack_index_in  = '0;
            prev_valid_in = 1'b0;
            prev_ack_in   = '0;
            dup_count_in  = '0;
            loss_in       = 1'b0;
         end else begin
            ack_index_in  = ack_index_ff + 7'd1;
            prev_ack_in   = req_ack_number;
            prev_valid_in = 1'b1;
            dup_count_in  = dup_upd;
            loss_in       = loss_upd;
         end
      end

      if (cmd.load_seg || cmd.load_ack) begin
         payload_in.window_now    = window_in;
         payload_in.threshold_now = threshold_in;
         payload_in.slow_start    = window_in < threshold_in;
      end

      if (csr_write) begin
         unique case (csr_addr)
            ADDR_INIT_WINDOW: begin
               init_window_in = csr_wdata;
               window_in      = clamp_wr_window;
            end
            ADDR_INIT_THRESHOLD: begin
               init_threshold_in = csr_wdata;
               threshold_in      = clamp_wr_threshold;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_window_ff    <= INIT_WINDOW_RESET;
         init_threshold_ff <= INIT_THRESHOLD_RESET;
         window_ff         <= INIT_WINDOW_RESET;
         threshold_ff      <= THRESHOLD_RESET;
         base_ack_ff       <= BASE_ACK_RESET;
         prev_ack_ff       <= '0;
         prev_valid_ff     <= 1'b0;
         dup_count_ff      <= '0;
         loss_ff           <= 1'b0;
         ack_index_ff      <= '0;
         seg_cnt_ff        <= '0;
      end else begin
         init_window_ff    <= init_window_in;
         init_threshold_ff <= init_threshold_in;
         window_ff         <= window_in;
         threshold_ff      <= threshold_in;
         base_ack_ff       <= base_ack_in;
         prev_ack_ff       <= prev_ack_in;
         prev_valid_ff     <= prev_valid_in;
         dup_count_ff      <= dup_count_in;
         loss_ff           <= loss_in;
         ack_index_ff      <= ack_index_in;
         seg_cnt_ff        <= seg_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
   end

endmodule

`default_nettype wire

// ===== rtl/tcp_congestion_window_round.sv =====
// ----------------------------------------------------------------------------
// tcp_congestion_window_round
// Round-based Tahoe-style sender window: segment runs and ACK window updates.
//
//   channel  dir  handshake              beat
//   req_ch   in   valid/ready            op, ack_number
//   rsp_ch   out  valid/ready            seq_number .. triple_dup_seen
//   csr      in   psel/penable/pready    paddr 0 window, 4 threshold
//
// ACK beat: one result beat; ACK beats may follow back to back.
// Send beat: opens the round, then window segments, one per cycle while the
// result slot is free, paced by the segment counter; no request taken meanwhile.
// Reset is synchronous and loads window 1, threshold 8 (clamped), base 1.
// A stalled result beat holds; the next request is taken in the same cycle
// the held beat leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_congestion_window_round
   import tcwr_pkg::*;
#(
   parameter int unsigned MAX_WINDOW = 64
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   tcwr_req_if.sink                   req_ch,
   tcwr_rsp_if.source                 rsp_ch,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);

   ctl_cmd_type     cmd;
   dp_status_type   status;
   rsp_payload_type payload;
   logic            csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   tcwr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_op    (req_ch.op),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tcwr_datapath #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_ack_number (req_ch.ack_number),
      .csr_write      (csr_write),
      .csr_addr       (paddr),
      .csr_wdata      (pwdata[WIN_W-1:0]),
      .csr_rdata      (prdata),
      .rsp_payload    (payload)
   );

   assign rsp_ch.seq_number      = payload.seq_number;
   assign rsp_ch.is_segment      = payload.is_segment;
   assign rsp_ch.last_of_run     = payload.last_of_run;
   assign rsp_ch.window_now      = payload.window_now;
   assign rsp_ch.threshold_now   = payload.threshold_now;
   assign rsp_ch.slow_start      = payload.slow_start;
   assign rsp_ch.triple_dup_seen = payload.triple_dup_seen;

endmodule

`default_nettype wire

// ===== rtl/tcwr_checker.sv =====
// ----------------------------------------------------------------------------
// tcwr_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tcwr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] seq_number,
   input wire logic        is_segment,
   input wire logic        last_of_run,
   input wire logic [6:0]  window_now,
   input wire logic [6:0]  threshold_now,
   input wire logic        slow_start,
   input wire logic        triple_dup_seen
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(seq_number) && $stable(window_now)
         && $stable(last_of_run))
      else $error("result beat changed while stalled");

   a_window_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> window_now != 7'd0 && window_now <= 7'd64 && threshold_now <= 7'd64)
      else $error("window or threshold out of range");

   a_ack_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !is_segment |-> last_of_run && seq_number == 32'd0)
      else $error("ACK status beat malformed");

   a_slow_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> slow_start == (window_now < threshold_now))
      else $error("slow start flag disagrees with window");

   a_segment_loss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && is_segment |-> !triple_dup_seen)
      else $error("segment beat carries loss flag");

endmodule

bind tcp_congestion_window_round tcwr_checker u_tcwr_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .seq_number      (rsp_ch.seq_number),
   .is_segment      (rsp_ch.is_segment),
   .last_of_run     (rsp_ch.last_of_run),
   .window_now      (rsp_ch.window_now),
   .threshold_now   (rsp_ch.threshold_now),
   .slow_start      (rsp_ch.slow_start),
   .triple_dup_seen (rsp_ch.triple_dup_seen)
);

`default_nettype wire

// ===== dv/tb_tcp_congestion_window_round.sv =====
// ----------------------------------------------------------------------------
// tb_tcp_congestion_window_round
// Self-checking bench for the round-based Tahoe congestion window block.
// A queue of send and ACK beats feeds a valid/ready driver; a clocked monitor
// predicts segment runs and ACK status beats from its own window model and
// checks each result beat field by field. Both channels stall at random, the
// result side holds off once for a long stretch, and the window and threshold
// registers are rewritten over APB between phases, extremes included.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_tcp_congestion_window_round;
   timeunit 1ns;
   timeprecision 1ps;

   import tcwr_pkg::*;

   localparam int MAX_WINDOW  = 64;
   localparam int STALL_LIMIT = 4000;
   localparam int HOLDOFF_LEN = 300;
   localparam int RANDOM_ITEMS = 460;

   typedef struct packed {
      logic [WIN_W-1:0] cwnd;
      logic [WIN_W-1:0] ssthresh;
      logic [ACK_W-1:0] base;
      logic [ACK_W-1:0] last_ack;
      logic             last_ok;
      logic [DUP_W-1:0] dups;
      logic             lost;
      logic [CNT_W-1:0] acks_seen;
   } tahoe_state_type;

   typedef struct packed {
      logic             op;
      logic [ACK_W-1:0] ack;
   } window_req_type;

   localparam tahoe_state_type RESET_STATE = '{INIT_WINDOW_RESET, INIT_THRESHOLD_RESET,
                                               BASE_ACK_RESET, '0, 1'b0, '0, 1'b0, '0};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   wire  [CSR_DATA_W-1:0] prdata;
   wire                   pready;

   logic             req_valid = 1'b0;
   logic             req_op = OP_SEND;
   logic [ACK_W-1:0] req_ack = '0;
   logic             req_taken = 1'b0;
   logic             rsp_ready = 1'b0;

   tahoe_state_type live = RESET_STATE;
   tahoe_state_type plan = RESET_STATE;
   window_req_type  pending_reqs[$];
   rsp_payload_type expected_beats[$];

   int          items_queued = 0;
   int          mismatches = 0;
   int          holdoff_left = 0;
   logic        holdoff_done = 1'b0;
   logic [31:0] cycle_count = '0;
   int          quiet_cycles = 0;
   wire         calm = (cycle_count[11:9] == 3'd1);

   tcwr_req_if req_ch ();
   tcwr_rsp_if rsp_ch ();

   assign req_ch.valid      = req_valid;
   assign req_ch.op         = req_op;
   assign req_ch.ack_number = req_ack;
   assign rsp_ch.ready      = rsp_ready;

   tcp_congestion_window_round #(.MAX_WINDOW(MAX_WINDOW)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [WIN_W-1:0] clamp_window(input int w);
      if (w < 1) return WIN_W'(1);
      if (w > MAX_WINDOW) return WIN_W'(MAX_WINDOW);
      return WIN_W'(w);
   endfunction

   function automatic tahoe_state_type fresh_round(input tahoe_state_type s);
      s.acks_seen = '0;
      s.last_ok   = 1'b0;
      s.last_ack  = '0;
      s.dups      = '0;
      s.lost      = 1'b0;
      return s;
   endfunction

   function automatic rsp_payload_type status_beat(input tahoe_state_type s,
                                                   input logic [SEQ_W-1:0] seq,
                                                   input logic seg, input logic last,
                                                   input logic loss);
      rsp_payload_type b;
      b.seq_number      = seq;
      b.is_segment      = seg;
      b.last_of_run     = last;
      b.window_now      = s.cwnd;
      b.threshold_now   = s.ssthresh;
      b.slow_start      = (s.cwnd < s.ssthresh);
      b.triple_dup_seen = loss;
      return b;
   endfunction

   function automatic tahoe_state_type load_register(input tahoe_state_type s,
                                                     input logic [CSR_ADDR_W-1:0] addr,
                                                     input logic [WIN_W-1:0] value);
      if (addr == ADDR_INIT_WINDOW)
         s.cwnd = clamp_window(int'(value));
      else if (addr == ADDR_INIT_THRESHOLD)
         s.ssthresh = (int'(value) > MAX_WINDOW) ? WIN_W'(MAX_WINDOW) : value;
      return s;
   endfunction

   // Advance the window by one beat and list the result beats it causes.
   function automatic int tahoe_step(inout tahoe_state_type s, input logic op,
                                     input logic [ACK_W-1:0] ack,
                                     output rsp_payload_type beats [MAX_WINDOW]);
      logic closed_lossy;
      if (op == OP_SEND) begin
         s = fresh_round(s);
         for (int i = 0; i < int'(s.cwnd); i++)
            beats[i] = status_beat(s, s.base + SEQ_W'(i), 1'b1, (i + 1 == int'(s.cwnd)), 1'b0);
         return int'(s.cwnd);
      end
      if (s.last_ok && ack == s.last_ack) begin
         if (s.dups < DUP_MAX)
            s.dups = s.dups + 1'b1;
         if (s.dups == DUP_LOSS)
            s.lost = 1'b1;
      end else begin
         s.dups = '0;
      end
      s.last_ack = ack;
      s.last_ok  = 1'b1;
      if (int'(s.acks_seen) + 1 >= int'(s.cwnd)) begin
         closed_lossy = s.lost;
         s.base = ack;
         if (closed_lossy) begin
            s.ssthresh = s.cwnd / 2;
            s.cwnd     = WIN_W'(1);
         end else if (s.cwnd < s.ssthresh) begin
            s.cwnd = clamp_window(2 * int'(s.cwnd));
         end else begin
            s.cwnd = clamp_window(int'(s.cwnd) + 1);
         end
         s = fresh_round(s);
         beats[0] = status_beat(s, '0, 1'b0, 1'b1, closed_lossy);
      end else begin
         s.acks_seen = s.acks_seen + 1'b1;
         beats[0] = status_beat(s, '0, 1'b0, 1'b1, s.lost);
      end
      return 1;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      $display("%0t ns mismatch %s: got %h, expected %h", $time, what, got, want);
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   task automatic queue_item(input logic op, input logic [ACK_W-1:0] ack);
      rsp_payload_type scratch [MAX_WINDOW];
      void'(tahoe_step(plan, op, ack, scratch));
      pending_reqs.push_back('{op, ack});
      items_queued++;
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || expected_beats.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [WIN_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      live = load_register(live, addr, value);
      plan = load_register(plan, addr, value);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Request driver: hold a beat until taken, else offer the next one.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_taken)
            void'(pending_reqs.pop_front());
         if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 22)) begin
            req_valid <= 1'b1;
            req_op    <= pending_reqs[0].op;
            req_ack   <= pending_reqs[0].ack;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset || holdoff_left != 0)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= calm || ($urandom_range(0, 99) >= 22);
   end

   // Hold off the result side once while the request queue is deep.
   always @(posedge clock) begin
      if (holdoff_left != 0) begin
         holdoff_left <= holdoff_left - 1;
      end else if (!reset && !holdoff_done && pending_reqs.size() > 30) begin
         holdoff_left <= HOLDOFF_LEN;
         holdoff_done <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_payload_type produced [MAX_WINDOW];
      rsp_payload_type want;
      int n;
      req_taken <= !reset && req_valid && req_ch.ready;
      if (!reset) begin
         if (req_valid && req_ch.ready) begin
            n = tahoe_step(live, req_op, req_ack, produced);
            for (int i = 0; i < n; i++)
               expected_beats.push_back(produced[i]);
         end
         if (rsp_ch.valid && rsp_ready) begin
            if (expected_beats.size() == 0) begin
               report_mismatch("beat with nothing expected", rsp_ch.seq_number, '0);
            end else begin
               want = expected_beats.pop_front();
               check_field("seq_number", rsp_ch.seq_number, want.seq_number);
               check_field("is_segment", rsp_ch.is_segment, want.is_segment);
               check_field("last_of_run", rsp_ch.last_of_run, want.last_of_run);
               check_field("window_now", rsp_ch.window_now, want.window_now);
               check_field("threshold_now", rsp_ch.threshold_now, want.threshold_now);
               check_field("slow_start", rsp_ch.slow_start, want.slow_start);
               check_field("triple_dup_seen", rsp_ch.triple_dup_seen, want.triple_dup_seen);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1'b1;
      if ((req_valid && req_ch.ready) || (rsp_ch.valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      logic [WIN_W-1:0] win_cfg;
      logic [WIN_W-1:0] thr_cfg;
      logic [ACK_W-1:0] ack_cursor;
      int roll;
      int acks_left;
      int dup_left;
      int quota;
      int phase;

      ack_cursor = 32'h0000_1000;
      dup_left   = 0;
      phase      = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Wrap the segment numbers, grow, then lose a round to duplicates.
      queue_item(OP_ACK, 32'hFFFF_FFFF);
      queue_item(OP_SEND, 32'h0000_0000);
      queue_item(OP_ACK, 32'h0000_0000);
      queue_item(OP_ACK, 32'h0000_0000);
      queue_item(OP_SEND, 32'hFFFF_FFFF);
      repeat (4) queue_item(OP_ACK, 32'd5);
      queue_item(OP_ACK, 32'd7);
      queue_item(OP_SEND, 32'h5555_5555);
      // Restart a round with a send; the next ACK is its first.
      queue_item(OP_ACK, 32'd9);
      queue_item(OP_SEND, 32'hAAAA_AAAA);
      queue_item(OP_ACK, 32'd9);
      queue_item(OP_ACK, 32'd9);
      queue_item(OP_SEND, 32'd0);
      drain();
      csr_write(ADDR_INIT_WINDOW, 7'd8);
      queue_item(OP_SEND, 32'd0);
      repeat (5) queue_item(OP_ACK, 32'd20);
      // Shrink the window mid-round so the lossy close leaves threshold zero.
      drain();
      csr_write(ADDR_INIT_WINDOW, 7'd0);
      queue_item(OP_ACK, 32'd21);
      queue_item(OP_ACK, 32'd22);
      queue_item(OP_ACK, 32'd23);
      queue_item(OP_ACK, 32'd24);

      while (items_queued < RANDOM_ITEMS - 30) begin
         drain();
         case (phase)
            0: begin win_cfg = 7'd33;  thr_cfg = 7'd127; end
            1: begin win_cfg = 7'd127; thr_cfg = 7'd0;   end
            2: begin win_cfg = 7'd0;   thr_cfg = 7'd64;  end
            default: begin
               if ($urandom_range(0, 7) == 0) begin
                  win_cfg = WIN_W'($urandom_range(0, 127));
                  thr_cfg = WIN_W'($urandom_range(0, 127));
               end else begin
                  win_cfg = WIN_W'($urandom_range(0, 8));
                  thr_cfg = WIN_W'($urandom_range(0, 20));
               end
            end
         endcase
         csr_write(ADDR_INIT_WINDOW, win_cfg);
         csr_write(ADDR_INIT_THRESHOLD, thr_cfg);
         quota = items_queued + $urandom_range(30, 70);
         while (items_queued < quota) begin
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
               case ($urandom_range(0, 3))
                  0:       queue_item(1'($urandom_range(0, 1)), '0);
                  1:       queue_item(1'($urandom_range(0, 1)), '1);
                  default: queue_item(1'($urandom_range(0, 1)), $urandom());
               endcase
            end else begin
               queue_item(OP_SEND, $urandom());
               acks_left = int'(plan.cwnd);
               if (roll < 22)
                  acks_left = $urandom_range(0, acks_left - 1);
               repeat (acks_left) begin
                  if (dup_left != 0)
                     dup_left--;
                  else if ($urandom_range(0, 99) < 20)
                     dup_left = $urandom_range(1, 4);
                  else if ($urandom_range(0, 99) < 10)
                     ack_cursor = $urandom();
                  else
                     ack_cursor = ack_cursor + ACK_W'($urandom_range(1, 1460));
                  queue_item(OP_ACK, ack_cursor);
               end
            end
         end
         phase++;
      end

      drain();
      if (mismatches == 0 && expected_beats.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire
